[hdl/cau_pkg.sv]
package cau_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_SUB    = 3'd1,
        FUNC_MUL    = 3'd2,
        FUNC_MULR   = 3'd3,
        FUNC_DIV    = 3'd4,
        FUNC_DIVR   = 3'd5,
        FUNC_EQ     = 3'd6,
        FUNC_NONE   = 3'd7
    } func_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } op_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_equal;
        logic               div_zero;
        logic               overflow;
    } res_t;

    // front classification that travels with each queued operation
    typedef struct packed {
        logic is_addsub;
        logic is_mul;
        logic is_div;
        logic is_eq;
    } cls_t;

    typedef struct packed {
        op_t  op;
        cls_t cls;
    } qent_t;

endpackage

[hdl/complex_arithmetic_unit.sv]
// Complex ALU on signed Q16.16 operands: add, sub, multiply, scale, divide,
// divide by real, equality. One transaction per cycle sustained while the output
// is not stalled; every operation passes through the pipelined restoring
// divider, which resolves one quotient bit per stage.
// A four-entry queue sits between input classification and the datapath.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // func[2:0], a_re, a_im, b_re, b_im, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // res_re, res_im, is_equal, div_zero, overflow, pad
);
    import cau_pkg::*;

    op_t   op;
    qent_t qd;
    logic  qv, qr;
    res_t  r;

    always_comb
    begin
        op.func = func_t'(s_tdata[2:0]);
        op.a_re = s_tdata[34:3];
        op.a_im = s_tdata[66:35];
        op.b_re = s_tdata[98:67];
        op.b_im = s_tdata[130:99];
    end

    cau_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(op),
        .q_valid(qv), .q_ready(qr), .q_data(qd)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(qv), .q_ready(qr), .q_data(qd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(r)
    );

    assign m_tdata = {5'b0, r.overflow, r.div_zero, r.is_equal, r.res_im, r.res_re};
endmodule

[hdl/cau_front.sv]
module cau_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cau_pkg::op_t  in_op,
    output logic          q_valid,
    input  logic          q_ready,
    output cau_pkg::qent_t q_data
);
    import cau_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    qent_t          mem [DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    cnt_reg;
    logic           push, pop;
    qent_t          ent;

    always_comb
    begin
        ent.op             = in_op;
        ent.cls.is_addsub  = (in_op.func == FUNC_ADD) || (in_op.func == FUNC_SUB);
        ent.cls.is_mul     = (in_op.func == FUNC_MUL) || (in_op.func == FUNC_MULR);
        ent.cls.is_div     = (in_op.func == FUNC_DIV) || (in_op.func == FUNC_DIVR);
        ent.cls.is_eq      = (in_op.func == FUNC_EQ);
    end

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_data   = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not grow");
    a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("empty queue with pointers apart");
`endif
endmodule

[hdl/cau_back.sv]
module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  cau_pkg::qent_t  q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cau_pkg::res_t   out_res
);
    import cau_pkg::*;

    // pipeline: s1 products, s2 sums, s3.. divider bit steps, then saturate
    localparam int NW   = 66;                // numerator width, signed
    localparam int MW   = NW + FRAC_BITS;    // dividend magnitude width
    localparam int DW   = 64;                // divisor magnitude width
    localparam int NST  = MW;                // one quotient bit per stage
    localparam int QW   = 34;                // kept quotient bits
    localparam int LAT  = NST + 4;

    logic adv;
    assign adv     = !out_valid || out_ready;
    assign q_ready = adv;

    // stage 1: four products
    logic               v1_reg;
    qent_t              e1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg   <= q_data;
            p_rr_reg <= q_data.op.a_re * q_data.op.b_re;
            p_ii_reg <= q_data.op.a_im * q_data.op.b_im;
            p_ir_reg <= q_data.op.a_im * q_data.op.b_re;
            p_ri_reg <= q_data.op.a_re * q_data.op.b_im;
        end
    end

    // stage 1b: squares of divisor, registered separately
    logic [63:0] sq_r_reg, sq_i_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_r_reg <= q_data.op.b_re * q_data.op.b_re;
            sq_i_reg <= q_data.op.b_im * q_data.op.b_im;
        end
    end

    // stage 2: sums, divider operands
    logic               v2_reg;
    qent_t              e2_reg;
    logic signed [NW-1:0] num_re_reg, num_im_reg;
    logic [DW-1:0]      den_reg;
    logic               dneg_reg, dz_reg;
    logic signed [NW-1:0] nre, nim;
    logic [DW:0]        dsum;
    logic [DW-1:0]      dnx;
    logic               dnegx, dzx;

    always_comb
    begin
        nre   = '0;
        nim   = '0;
        dnx   = '0;
        dnegx = 1'b0;
        dsum  = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
        unique case (e1_reg.op.func)
            FUNC_ADD:
            begin
                nre = NW'(e1_reg.op.a_re) + NW'(e1_reg.op.b_re);
                nim = NW'(e1_reg.op.a_im) + NW'(e1_reg.op.b_im);
            end
            FUNC_SUB:
            begin
                nre = NW'(e1_reg.op.a_re) - NW'(e1_reg.op.b_re);
                nim = NW'(e1_reg.op.a_im) - NW'(e1_reg.op.b_im);
            end
            FUNC_MUL:
            begin
                nre = NW'(p_rr_reg) - NW'(p_ii_reg);
                nim = NW'(p_ir_reg) + NW'(p_ri_reg);
            end
            FUNC_MULR:
            begin
                nre = NW'(p_rr_reg);
                nim = NW'(p_ir_reg);
            end
            FUNC_DIV:
            begin
                nre = NW'(p_rr_reg) + NW'(p_ii_reg);
                nim = NW'(p_ir_reg) - NW'(p_ri_reg);
                dnx = dsum[DW-1:0];
            end
            FUNC_DIVR:
            begin
                nre   = NW'(e1_reg.op.a_re);
                nim   = NW'(e1_reg.op.a_im);
                dnegx = e1_reg.op.b_re[31];
                dnx   = e1_reg.op.b_re[31] ? DW'(-65'(e1_reg.op.b_re))
                                           : DW'(e1_reg.op.b_re);
            end
            default: ;
        endcase
        dzx = (dnx == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_reg     <= e1_reg;
            num_re_reg <= nre;
            num_im_reg <= nim;
            den_reg    <= dnx;
            dneg_reg   <= dnegx;
            dz_reg     <= dzx;
        end
    end

    // divider: one restoring step per stage per part
    typedef struct packed {
        logic [MW-1:0]  m_re, m_im;
        logic [DW:0]    r_re, r_im;
        logic [QW-1:0]  q_re, q_im;
        logic           ng_re, ng_im;
    } dst_t;

    dst_t          ds_reg   [NST+1];
    qent_t         de_reg   [NST+1];
    logic [DW-1:0] dd_reg   [NST+1];
    logic          ddz_reg  [NST+1];
    logic signed [NW-1:0] dnr_reg [NST+1], dni_reg [NST+1];
    dst_t          ds0;
    logic [NW-1:0] mag_re, mag_im;

    always_comb
    begin
        mag_re = num_re_reg[NW-1] ? NW'(-num_re_reg) : NW'(num_re_reg);
        mag_im = num_im_reg[NW-1] ? NW'(-num_im_reg) : NW'(num_im_reg);
        ds0.m_re  = {mag_re, {FRAC_BITS{1'b0}}};
        ds0.m_im  = {mag_im, {FRAC_BITS{1'b0}}};
        ds0.r_re  = '0;
        ds0.r_im  = '0;
        ds0.q_re  = '0;
        ds0.q_im  = '0;
        ds0.ng_re = num_re_reg[NW-1] ^ dneg_reg;
        ds0.ng_im = num_im_reg[NW-1] ^ dneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0]  <= ds0;
            de_reg[0]  <= e2_reg;
            dd_reg[0]  <= den_reg;
            ddz_reg[0] <= dz_reg;
            dnr_reg[0] <= num_re_reg;
            dni_reg[0] <= num_im_reg;
        end
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_div
        dst_t       nx;
        logic [DW:0] tr, ti;
        always_comb
        begin
            nx = ds_reg[s];
            tr = {ds_reg[s].r_re[DW-1:0], ds_reg[s].m_re[MW-1]};
            ti = {ds_reg[s].r_im[DW-1:0], ds_reg[s].m_im[MW-1]};
            nx.m_re = ds_reg[s].m_re << 1;
            nx.m_im = ds_reg[s].m_im << 1;
            // quotient sticky-saturates into the top kept bit
            if (tr >= {1'b0, dd_reg[s]})
            begin
                nx.r_re = tr - {1'b0, dd_reg[s]};
                nx.q_re = {ds_reg[s].q_re[QW-2] | ds_reg[s].q_re[QW-1],
                           ds_reg[s].q_re[QW-3:0], 1'b1};
            end
            else
            begin
                nx.r_re = tr;
                nx.q_re = {ds_reg[s].q_re[QW-2] | ds_reg[s].q_re[QW-1],
                           ds_reg[s].q_re[QW-3:0], 1'b0};
            end
            if (ti >= {1'b0, dd_reg[s]})
            begin
                nx.r_im = ti - {1'b0, dd_reg[s]};
                nx.q_im = {ds_reg[s].q_im[QW-2] | ds_reg[s].q_im[QW-1],
                           ds_reg[s].q_im[QW-3:0], 1'b1};
            end
            else
            begin
                nx.r_im = ti;
                nx.q_im = {ds_reg[s].q_im[QW-2] | ds_reg[s].q_im[QW-1],
                           ds_reg[s].q_im[QW-3:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ds_reg[s+1]  <= nx;
                de_reg[s+1]  <= de_reg[s];
                dd_reg[s+1]  <= dd_reg[s];
                ddz_reg[s+1] <= ddz_reg[s];
                dnr_reg[s+1] <= dnr_reg[s];
                dni_reg[s+1] <= dni_reg[s];
            end
        end
    end

    // final stage: pick, shift, saturate
    function automatic logic [32:0] sat_s(input logic signed [NW-1:0] x);
        logic [32:0] r;
        if (x > NW'(64'sh7FFFFFFF))
            r = {1'b1, 32'h7FFFFFFF};
        else if (x < -NW'(65'sh80000000))
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, x[31:0]};
        return r;
    endfunction

    function automatic logic [32:0] sat_q(input logic [QW-1:0] q, input logic ng);
        logic [32:0] r;
        if (!ng && q > QW'(33'h7FFFFFFF))
            r = {1'b1, 32'h7FFFFFFF};
        else if (ng && q > QW'(33'h80000000))
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, ng ? 32'(-q) : q[31:0]};
        return r;
    endfunction

    qent_t         ef;
    dst_t          df;
    res_t          rn;
    logic [32:0]   sr, si;
    logic signed [NW-1:0] shr, shi;

    always_comb
    begin
        ef  = de_reg[NST];
        df  = ds_reg[NST];
        shr = dnr_reg[NST] >>> FRAC_BITS;
        shi = dni_reg[NST] >>> FRAC_BITS;
        sr  = '0;
        si  = '0;
        rn  = '0;
        priority if (ef.cls.is_addsub)
        begin
            sr = sat_s(dnr_reg[NST]);
            si = sat_s(dni_reg[NST]);
        end
        else if (ef.cls.is_mul)
        begin
            sr = sat_s(shr);
            si = sat_s(shi);
        end
        else if (ef.cls.is_div)
        begin
            if (ddz_reg[NST])
                rn.div_zero = 1'b1;
            else
            begin
                sr = sat_q(df.q_re, df.ng_re);
                si = sat_q(df.q_im, df.ng_im);
            end
        end
        else if (ef.cls.is_eq)
            rn.is_equal = (ef.op.a_re == ef.op.b_re) && (ef.op.a_im == ef.op.b_im);
        rn.res_re   = sr[31:0];
        rn.res_im   = si[31:0];
        rn.overflow = sr[32] | si[32];
    end

    // valid shift line
    logic [LAT-1:0] vl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vl_reg <= '0;
        else if (adv)
            vl_reg <= {vl_reg[LAT-2:0], q_valid};
    end
    assign v1_reg = vl_reg[0];
    assign v2_reg = vl_reg[1];

    always_ff @(posedge clk)
    begin
        if (adv)
            out_res <= rn;
    end
    assign out_valid = vl_reg[LAT-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vl_reg))
        else $error("pipeline moved under stall");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_res.is_equal && out_res.div_zero))
        else $error("conflicting result flags");
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.div_zero) |-> (out_res.res_re == '0 && !out_res.overflow))
        else $error("zero divisor with nonzero result");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && q_valid) |=> vl_reg[0])
        else $error("accepted op lost");
    a_v2: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v1_reg) |=> v2_reg)
        else $error("stage valid lost");
`endif
endmodule
